/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define USP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define USP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/usp_pkg.sv */
// shared types and constants of the sensor poll engine
package usp_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned QUERY_W    = 6;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_COMMAND    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_MARKER = 8'd3;

  // configuration reset values
  localparam logic [BYTE_W-1:0] START_MARKER_RST    = 8'hAA;
  localparam logic [BYTE_W-1:0] READ_COMMAND_RST    = 8'h01;
  localparam logic [BYTE_W-1:0] RESPONSE_MARKER_RST = 8'hBB;

  // fixed length byte of a read request
  localparam logic [BYTE_W-1:0] REQUEST_LENGTH = 8'h02;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_ANSWER
  } ctl_state_t;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_RECEIVE = 2'd2
  } parse_phase_t;

  // which request byte goes out
  typedef enum logic [1:0] {
    SEL_START,
    SEL_CMD,
    SEL_REG,
    SEL_LEN
  } emit_sel_t;

  typedef struct packed {
    logic      rx_take;
    logic      scan_start;
    logic      scan_step;
    logic      scan_take;
    logic      query_rd;
    logic      load_byte;
    emit_sel_t sel;
    logic      load_answer;
  } usp_cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } usp_status_t;

endpackage

/* design/usp_in_if.sv */
// input word channel
interface usp_in_if;
  logic                           valid;
  logic                           ready;
  logic [usp_pkg::FUNC_W-1:0]     func;
  logic [usp_pkg::BYTE_W-1:0]     rx_byte;
  logic [usp_pkg::QUERY_W-1:0]    query_reg;

  modport source (output valid, output func, output rx_byte, output query_reg, input ready);
  modport sink (input valid, input func, input rx_byte, input query_reg, output ready);
endinterface

/* design/usp_out_if.sv */
// result word channel
interface usp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [usp_pkg::BYTE_W-1:0]          tx_byte;
  logic                                last_of_run;
  logic signed [usp_pkg::VALUE_W-1:0]  stored_value;

  modport source (output valid, output kind, output tx_byte, output last_of_run,
                  output stored_value, input ready);
  modport sink (input valid, input kind, input tx_byte, input last_of_run,
                input stored_value, output ready);
endinterface

/* design/usp_cfg_if.sv */
// configuration write channel
interface usp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [usp_pkg::CFG_IDX_W-1:0]     index;
  logic [usp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/usp_ctrl.sv */
// controller state machine of the sensor poll engine
module usp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [usp_pkg::FUNC_W-1:0]   in_func,
  output logic                         in_ready,
  input  usp_pkg::usp_status_t         status,
  output usp_pkg::usp_cmd_t            cmd
);

  usp_pkg::ctl_state_t state_r, state_nxt;
  usp_pkg::emit_sel_t  emit_r, emit_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= usp_pkg::ST_IDLE;
      emit_r  <= usp_pkg::SEL_START;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = emit_r;
    unique case (state_r)
      usp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            usp_pkg::FUNC_RX: begin
              cmd.rx_take = 1'b1;
            end
            usp_pkg::FUNC_POLL: begin
              cmd.scan_start = 1'b1;
              state_nxt      = usp_pkg::ST_SCAN;
            end
            usp_pkg::FUNC_QUERY: begin
              cmd.query_rd = 1'b1;
              state_nxt    = usp_pkg::ST_ANSWER;
            end
            default: begin
              state_nxt = usp_pkg::ST_IDLE;
            end
          endcase
        end
      end
      usp_pkg::ST_SCAN: begin
        priority if (status.scan_hit) begin
          cmd.scan_take = 1'b1;
          emit_nxt      = usp_pkg::SEL_START;
          state_nxt     = usp_pkg::ST_EMIT;
        end else if (status.scan_last) begin
          state_nxt = usp_pkg::ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      usp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_byte = 1'b1;
          unique case (emit_r)
            usp_pkg::SEL_START: emit_nxt = usp_pkg::SEL_CMD;
            usp_pkg::SEL_CMD:   emit_nxt = usp_pkg::SEL_REG;
            usp_pkg::SEL_REG:   emit_nxt = usp_pkg::SEL_LEN;
            default: begin
              emit_nxt  = usp_pkg::SEL_START;
              state_nxt = usp_pkg::ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        if (status.out_free) begin
          cmd.load_answer = 1'b1;
          state_nxt       = usp_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

/* design/usp_dpath.sv */
// datapath: config, parser, poll scan, value table and output register
module usp_dpath #(
  parameter int unsigned NUM_REGS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  usp_pkg::usp_cmd_t                   cmd,
  output usp_pkg::usp_status_t                status,
  input  logic [usp_pkg::BYTE_W-1:0]          in_rx_byte,
  input  logic [usp_pkg::QUERY_W-1:0]         in_query_reg,
  input  logic                                cfg_wr,
  input  logic [usp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [usp_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_kind,
  output logic [usp_pkg::BYTE_W-1:0]          out_tx_byte,
  output logic                                out_last_of_run,
  output logic signed [usp_pkg::VALUE_W-1:0]  out_stored_value
);

  localparam int unsigned IDX_W = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_REGS - 1);

  // configuration registers
  logic [NUM_REGS-1:0]         enable_r;
  logic [usp_pkg::BYTE_W-1:0]  start_r;
  logic [usp_pkg::BYTE_W-1:0]  rdcmd_r;
  logic [usp_pkg::BYTE_W-1:0]  resp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      start_r  <= usp_pkg::START_MARKER_RST;
      rdcmd_r  <= usp_pkg::READ_COMMAND_RST;
      resp_r   <= usp_pkg::RESPONSE_MARKER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        usp_pkg::CFG_ENABLE_MASK:     enable_r <= cfg_data[NUM_REGS-1:0];
        usp_pkg::CFG_START_MARKER:    start_r  <= cfg_data[usp_pkg::BYTE_W-1:0];
        usp_pkg::CFG_READ_COMMAND:    rdcmd_r  <= cfg_data[usp_pkg::BYTE_W-1:0];
        usp_pkg::CFG_RESPONSE_MARKER: resp_r   <= cfg_data[usp_pkg::BYTE_W-1:0];
        default: enable_r <= enable_r;
      endcase
    end
  end

  // response parser
  usp_pkg::parse_phase_t       phase_r, phase_nxt;
  logic [usp_pkg::BYTE_W-1:0]  len_r, len_nxt;
  logic [usp_pkg::BYTE_W-1:0]  cnt_r, cnt_nxt;
  logic [usp_pkg::BYTE_W-1:0]  plo_r, plo_nxt;
  logic [usp_pkg::BYTE_W-1:0]  phi_r, phi_nxt;
  logic                        tbl_we;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    tbl_we    = 1'b0;
    if (cmd.rx_take) begin
      unique case (phase_r)
        usp_pkg::PH_LENGTH: begin
          len_nxt   = in_rx_byte;
          cnt_nxt   = '0;
          phase_nxt = (in_rx_byte == '0) ? usp_pkg::PH_WAIT : usp_pkg::PH_RECEIVE;
        end
        usp_pkg::PH_RECEIVE: begin
          if (cnt_r == 8'd0) begin
            plo_nxt = in_rx_byte;
          end else if (cnt_r == 8'd1) begin
            phi_nxt = in_rx_byte;
          end
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt == len_r) begin
            phase_nxt = usp_pkg::PH_WAIT;
            tbl_we    = 1'b1;
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == resp_r) ? usp_pkg::PH_LENGTH : usp_pkg::PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= usp_pkg::PH_WAIT;
      len_r   <= '0;
      cnt_r   <= '0;
      plo_r   <= '0;
      phi_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
    end
  end

  // round-robin scan, one register a cycle
  logic [IDX_W-1:0] ptr_r, pend_r, cand_r, scnt_r;
  logic [IDX_W-1:0] ptr_inc, cand_inc;

  assign ptr_inc  = (ptr_r == IDX_LAST) ? '0 : ptr_r + 1'b1;
  assign cand_inc = (cand_r == IDX_LAST) ? '0 : cand_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      pend_r <= '0;
      cand_r <= '0;
      scnt_r <= '0;
    end else begin
      if (cmd.scan_start) begin
        cand_r <= ptr_inc;
        scnt_r <= '0;
      end else if (cmd.scan_step) begin
        cand_r <= cand_inc;
        scnt_r <= scnt_r + 1'b1;
      end
      if (cmd.scan_take) begin
        ptr_r  <= cand_r;
        pend_r <= cand_r;
      end
    end
  end

  assign status.scan_hit  = enable_r[cand_r];
  assign status.scan_last = (scnt_r == IDX_LAST);

  // value table with per-entry valid bits
  logic [usp_pkg::VALUE_W-1:0] tbl_mem [NUM_REGS];
  logic [NUM_REGS-1:0]         tbl_vld_r;
  logic [usp_pkg::VALUE_W-1:0] rd_data_r;
  logic                        rd_ok_r;
  logic [IDX_W-1:0]            qidx;
  logic                        q_in_range;

  assign qidx       = in_query_reg[IDX_W-1:0];
  assign q_in_range = ({1'b0, in_query_reg} < (usp_pkg::QUERY_W + 1)'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[pend_r] <= {phi_nxt, plo_nxt};
    end
    if (cmd.query_rd) begin
      rd_data_r <= tbl_mem[qidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld_r[pend_r] <= 1'b1;
      end
      if (cmd.query_rd) begin
        rd_ok_r <= q_in_range && tbl_vld_r[qidx];
      end
    end
  end

  // request byte select
  logic [usp_pkg::BYTE_W-1:0] frame_byte;

  always_comb begin
    unique case (cmd.sel)
      usp_pkg::SEL_START: frame_byte = start_r;
      usp_pkg::SEL_CMD:   frame_byte = rdcmd_r;
      usp_pkg::SEL_REG:   frame_byte = usp_pkg::BYTE_W'(ptr_r);
      default:            frame_byte = usp_pkg::REQUEST_LENGTH;
    endcase
  end

  // output register
  logic                        out_vld_r;
  logic                        out_kind_r;
  logic [usp_pkg::BYTE_W-1:0]  out_tx_r;
  logic                        out_last_r;
  logic [usp_pkg::VALUE_W-1:0] out_val_r;

  assign status.out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_byte || cmd.load_answer) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_kind_r <= usp_pkg::KIND_TX;
      out_tx_r   <= frame_byte;
      out_last_r <= (cmd.sel == usp_pkg::SEL_LEN);
      out_val_r  <= '0;
    end else if (cmd.load_answer) begin
      out_kind_r <= usp_pkg::KIND_ANSWER;
      out_tx_r   <= '0;
      out_last_r <= 1'b1;
      out_val_r  <= rd_ok_r ? rd_data_r : '0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = out_kind_r;
  assign out_tx_byte      = out_tx_r;
  assign out_last_of_run  = out_last_r;
  assign out_stored_value = $signed(out_val_r);

endmodule

/* design/uart_sensor_poll_engine.sv */
// top level of the round-robin sensor poll engine
//
//   channel  dir  word                                         handshake
//   in_s     in   func, rx_byte, query_reg                     valid/ready
//   out_s    out  kind, tx_byte, last_of_run, stored_value     valid/ready
//   cfg_s    in   index, data                                  valid/ready, always ready
//
// received byte: in_ready again on the next cycle
// query: registered table read, then the answer enters the output register
// poll tick: scans one to NUM_REGS registers (one register per cycle), then, on a hit, four
//   request bytes, one per cycle while the output register drains
// reset clears all control state and the table valid bits
// a stalled output holds its word; no new word is loaded until it is taken
module uart_sensor_poll_engine #(
  parameter int unsigned NUM_REGS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  usp_in_if.sink            in_s,
  usp_out_if.source         out_s,
  usp_cfg_if.sink           cfg_s
);

  usp_pkg::usp_cmd_t    cmd;
  usp_pkg::usp_status_t status;
  logic                 cfg_wr;

  // config writes are taken at any time
  assign cfg_s.ready = 1'b1;
  assign cfg_wr      = cfg_s.valid;

  usp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_func  (in_s.func),
    .in_ready (in_s.ready),
    .status   (status),
    .cmd      (cmd)
  );

  usp_dpath #(
    .NUM_REGS (NUM_REGS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_rx_byte       (in_s.rx_byte),
    .in_query_reg     (in_s.query_reg),
    .cfg_wr           (cfg_wr),
    .cfg_index        (cfg_s.index),
    .cfg_data         (cfg_s.data),
    .out_valid        (out_s.valid),
    .out_ready        (out_s.ready),
    .out_kind         (out_s.kind),
    .out_tx_byte      (out_s.tx_byte),
    .out_last_of_run  (out_s.last_of_run),
    .out_stored_value (out_s.stored_value)
  );

endmodule

/* design/usp_checker.sv */
// port-level checks of the sensor poll engine and their bind
`include "assert_macros.svh"

module usp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [usp_pkg::FUNC_W-1:0]          in_func,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_kind,
  input logic [usp_pkg::BYTE_W-1:0]          out_tx_byte,
  input logic                                out_last_of_run,
  input logic signed [usp_pkg::VALUE_W-1:0]  out_stored_value
);

  logic in_acc;
  logic out_acc;
  logic rx_acc;
  logic poll_acc;
  logic frame_end;
  logic out_stall;
  logic [usp_pkg::BYTE_W+usp_pkg::VALUE_W+1:0] out_word;

  assign in_acc    = rst_n && in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign rx_acc    = in_acc && (in_func == usp_pkg::FUNC_RX);
  assign poll_acc  = in_acc && (in_func == usp_pkg::FUNC_POLL);
  assign frame_end = out_acc && (out_kind == usp_pkg::KIND_TX) && out_last_of_run;
  assign out_stall = rst_n && out_valid && !out_ready;
  assign out_word  = {out_kind, out_tx_byte, out_last_of_run, out_stored_value};

  // a received byte leaves the block ready on the next cycle
  `USP_ASSERT_NEXT(a_rx_quick, rx_acc, in_ready, "rx byte stalled input")

  // a poll tick is always followed by a scan, during which input is not ready
  `USP_ASSERT_NEXT(a_poll_busy, poll_acc, !in_ready, "poll tick not scanned")

  // last request byte is the fixed length
  `USP_ASSERT_SAME(a_frame_end, frame_end, out_tx_byte == usp_pkg::REQUEST_LENGTH, "bad frame end")

  // stalled output word holds
  `USP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "output changed under stall")

endmodule

bind uart_sensor_poll_engine usp_checker u_usp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .in_func          (in_s.func),
  .out_valid        (out_s.valid),
  .out_ready        (out_s.ready),
  .out_kind         (out_s.kind),
  .out_tx_byte      (out_s.tx_byte),
  .out_last_of_run  (out_s.last_of_run),
  .out_stored_value (out_s.stored_value)
);

/* tb/tb.sv */
// self-checking testbench for the round-robin sensor poll engine
`timescale 1ns / 1ps

module tb;

  localparam int NREG        = 64;
  localparam int DRAIN       = NREG + 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // func code with no effect on the engine
  localparam logic [usp_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [usp_pkg::FUNC_W-1:0]  func;
    logic [usp_pkg::BYTE_W-1:0]  rx_byte;
    logic [usp_pkg::QUERY_W-1:0] query_reg;
  } cmd_word_t;

  typedef struct packed {
    logic                               kind;
    logic [usp_pkg::BYTE_W-1:0]         tx_byte;
    logic                               last;
    logic signed [usp_pkg::VALUE_W-1:0] value;
  } res_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  usp_in_if  in_ch ();
  usp_out_if out_ch ();
  usp_cfg_if cfg_ch ();

  uart_sensor_poll_engine #(.NUM_REGS(NREG)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg_s (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pending command words and predicted result words
  cmd_word_t cmd_q[$];
  res_word_t exp_words[$];
  int        cmd_total = 0;
  int        errors    = 0;
  int        cycle_cnt = 0;
  int        src_idle_pct  = 0;
  int        snk_stall_pct = 0;
  int        hold_req  = 0;
  int        hold_ack  = 0;
  int        hold_left = 0;

  // generator's view of the settings it wrote
  logic [63:0]                gen_mask = '0;
  logic [usp_pkg::BYTE_W-1:0] gen_resp = usp_pkg::RESPONSE_MARKER_RST;

  // predictor state and configuration
  logic [63:0]                 m_en_mask  = '0;
  logic [usp_pkg::BYTE_W-1:0]  m_start_mk = usp_pkg::START_MARKER_RST;
  logic [usp_pkg::BYTE_W-1:0]  m_rd_cmd   = usp_pkg::READ_COMMAND_RST;
  logic [usp_pkg::BYTE_W-1:0]  m_resp_mk  = usp_pkg::RESPONSE_MARKER_RST;
  usp_pkg::parse_phase_t       m_phase    = usp_pkg::PH_WAIT;
  logic [7:0]                  m_len      = '0;
  logic [7:0]                  m_cnt      = '0;
  logic [usp_pkg::BYTE_W-1:0]  m_lo       = '0;
  logic [usp_pkg::BYTE_W-1:0]  m_hi       = '0;
  logic [usp_pkg::QUERY_W-1:0] m_pend     = '0;
  logic [usp_pkg::QUERY_W-1:0] m_poll_ptr = '0;
  logic [usp_pkg::VALUE_W-1:0] m_table [NREG] = '{default: '0};

  task automatic add_tx_word(input logic [usp_pkg::BYTE_W-1:0] b, input logic last);
    res_word_t w;
    w.kind    = usp_pkg::KIND_TX;
    w.tx_byte = b;
    w.last    = last;
    w.value   = '0;
    exp_words.push_back(w);
  endtask

  // response parser: marker, length, payload
  task automatic parse_rx_byte(input logic [usp_pkg::BYTE_W-1:0] b);
    case (m_phase)
      usp_pkg::PH_LENGTH: begin
        m_len   = b;
        m_cnt   = '0;
        m_phase = (b == 8'd0) ? usp_pkg::PH_WAIT : usp_pkg::PH_RECEIVE;
      end
      usp_pkg::PH_RECEIVE: begin
        if (m_cnt == 8'd0) m_lo = b;
        else if (m_cnt == 8'd1) m_hi = b;
        m_cnt = m_cnt + 8'd1;
        if (m_cnt == m_len) begin
          m_phase = usp_pkg::PH_WAIT;
          if (m_pend < NREG) m_table[m_pend] = {m_hi, m_lo};
        end
      end
      default: m_phase = (b == m_resp_mk) ? usp_pkg::PH_LENGTH : usp_pkg::PH_WAIT;
    endcase
  endtask

  // next state and result words for one accepted command word
  task automatic poll_engine_step(input cmd_word_t c);
    logic [usp_pkg::QUERY_W-1:0] r;
    logic                        hit;
    res_word_t                   w;
    case (c.func)
      usp_pkg::FUNC_RX: parse_rx_byte(c.rx_byte);
      usp_pkg::FUNC_POLL: begin
        hit = 1'b0;
        // full circle after the pointer, ending on the pointer itself
        for (int i = 1; i <= NREG; i++) begin
          r = 6'((int'(m_poll_ptr) + i) % NREG);
          if (!hit && m_en_mask[r]) begin
            hit        = 1'b1;
            m_poll_ptr = r;
            m_pend     = r;
            add_tx_word(m_start_mk, 1'b0);
            add_tx_word(m_rd_cmd, 1'b0);
            add_tx_word({2'b00, r}, 1'b0);
            add_tx_word(usp_pkg::REQUEST_LENGTH, 1'b1);
          end
        end
      end
      usp_pkg::FUNC_QUERY: begin
        w.kind    = usp_pkg::KIND_ANSWER;
        w.tx_byte = '0;
        w.last    = 1'b1;
        w.value   = (c.query_reg < NREG) ? m_table[c.query_reg] : '0;
        exp_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  // driver: offers queued command words, predicts on acceptance
  always @(posedge clk) begin : drv
    cmd_word_t nxt;
    logic      v;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= usp_pkg::FUNC_RX;
      in_ch.rx_byte   <= '0;
      in_ch.query_reg <= '0;
    end else begin
      v = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        poll_engine_step(cmd_q.pop_front());
        v = 1'b0;
      end
      if (!v && cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = cmd_q[0];
        in_ch.func      <= nxt.func;
        in_ch.rx_byte   <= nxt.rx_byte;
        in_ch.query_reg <= nxt.query_reg;
        v = 1'b1;
      end
      in_ch.valid <= v;
    end
  end

  // config writes reach the predictor when the engine takes them
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        usp_pkg::CFG_ENABLE_MASK:     m_en_mask  <= cfg_ch.data;
        usp_pkg::CFG_START_MARKER:    m_start_mk <= cfg_ch.data[usp_pkg::BYTE_W-1:0];
        usp_pkg::CFG_READ_COMMAND:    m_rd_cmd   <= cfg_ch.data[usp_pkg::BYTE_W-1:0];
        usp_pkg::CFG_RESPONSE_MARKER: m_resp_mk  <= cfg_ch.data[usp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic note_error(input string what, input res_word_t want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%s: want kind %0d tx %02h last %0d val %0d, got kind %0d tx %02h last %0d val %0d",
               what, want.kind, want.tx_byte, want.last, want.value,
               out_ch.kind, out_ch.tx_byte, out_ch.last_of_run, out_ch.stored_value);
  endtask

  // monitor: checks each taken result word, drives ready
  always @(posedge clk) begin : mon
    res_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_words.size() == 0) begin
        want = '0;
        note_error("unexpected word", want);
      end else begin
        want = exp_words.pop_front();
        if (out_ch.kind !== want.kind || out_ch.tx_byte !== want.tx_byte ||
            out_ch.last_of_run !== want.last || out_ch.stored_value !== want.value)
          note_error("mismatch", want);
      end
    end
    out_ch.ready <= rst_n && hold_left == 0 && ($urandom_range(99) >= snk_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("uart_sensor_poll_engine regression: fail");
      $finish;
    end
  end

  task automatic push_cmd(input logic [usp_pkg::FUNC_W-1:0] f,
                          input logic [usp_pkg::BYTE_W-1:0] b,
                          input logic [usp_pkg::QUERY_W-1:0] q);
    cmd_word_t c;
    c.func      = f;
    c.rx_byte   = b;
    c.query_reg = q;
    cmd_q.push_back(c);
    cmd_total++;
  endtask

  task automatic push_rx(input logic [usp_pkg::BYTE_W-1:0] b);
    push_cmd(usp_pkg::FUNC_RX, b, 6'($urandom));
  endtask

  task automatic push_poll();
    push_cmd(usp_pkg::FUNC_POLL, 8'($urandom), 6'($urandom));
  endtask

  task automatic push_query(input logic [usp_pkg::QUERY_W-1:0] q);
    push_cmd(usp_pkg::FUNC_QUERY, 8'($urandom), q);
  endtask

  task automatic send_frame(input int len, input int nbytes);
    push_rx(gen_resp);
    push_rx(8'(len));
    for (int k = 0; k < nbytes; k++) push_rx(8'($urandom));
  endtask

  // mostly an enabled register, so answers carry polled data
  function automatic logic [usp_pkg::QUERY_W-1:0] pick_reg();
    logic [usp_pkg::QUERY_W-1:0] r;
    r = 6'($urandom);
    for (int k = 0; k < 16 && !gen_mask[r]; k++) r = 6'($urandom);
    return r;
  endfunction

  task automatic random_burst(input int n);
    int first;
    int sel;
    int len;
    first = cmd_total;
    while (cmd_total - first < n) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        // poll, then the sensor answers
        push_poll();
        len = ($urandom_range(9) == 0) ? $urandom_range(3, 6) : 2;
        send_frame(len, len);
        if ($urandom_range(1) == 1) push_query(pick_reg());
      end else if (sel < 48) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        send_frame(len, len);
      end else if (sel < 54) begin
        // payload cut short
        len = $urandom_range(3, 6);
        send_frame(len, $urandom_range(0, len - 1));
      end else if (sel < 60) begin
        // poll lands between payload bytes
        push_rx(gen_resp);
        push_rx(usp_pkg::REQUEST_LENGTH);
        push_rx(8'($urandom));
        push_poll();
        push_rx(8'($urandom));
        push_query(pick_reg());
      end else if (sel < 76) begin
        push_query(($urandom_range(1) == 1) ? pick_reg() : 6'($urandom));
      end else if (sel < 86) begin
        push_poll();
      end else if (sel < 95) begin
        push_rx(8'($urandom));
      end else begin
        push_cmd(FUNC_NONE, 8'($urandom), 6'($urandom));
      end
    end
  endtask

  task automatic cfg_write(input logic [usp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [usp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == usp_pkg::CFG_ENABLE_MASK) gen_mask = val;
    if (idx == usp_pkg::CFG_RESPONSE_MARKER) gen_resp = val[usp_pkg::BYTE_W-1:0];
  endtask

  // everything accepted and answered, then let a scan run out
  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_ch.valid || exp_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_phase(input logic [63:0] mask,
                           input logic [usp_pkg::BYTE_W-1:0] start_mk,
                           input logic [usp_pkg::BYTE_W-1:0] rd_cmd,
                           input logic [usp_pkg::BYTE_W-1:0] resp_mk,
                           input int src_pct, input int snk_pct);
    cfg_write(usp_pkg::CFG_ENABLE_MASK, mask);
    cfg_write(usp_pkg::CFG_START_MARKER, {56'd0, start_mk});
    cfg_write(usp_pkg::CFG_READ_COMMAND, {56'd0, rd_cmd});
    cfg_write(usp_pkg::CFG_RESPONSE_MARKER, {56'd0, resp_mk});
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  initial begin : main
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = usp_pkg::CFG_ENABLE_MASK;
    cfg_ch.data     = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: nothing enabled, table reads zero
    push_poll();
    push_query(6'd0);
    push_query(6'd63);
    push_cmd(FUNC_NONE, 8'hFF, 6'h3F);
    push_rx(8'h00);
    push_rx(8'hFF);
    send_frame(0, 0);
    push_query(6'd0);
    wait_drained();

    // lone enabled register is polled again on every tick
    cfg_write(usp_pkg::CFG_ENABLE_MASK, 64'h20);
    push_poll();
    push_poll();
    // low byte taken unsigned, high byte sign
    push_rx(gen_resp);
    push_rx(8'd2);
    push_rx(8'hFF);
    push_rx(8'h80);
    push_query(6'd5);
    // length of one keeps the old high byte
    push_rx(gen_resp);
    push_rx(8'd1);
    push_rx(8'h34);
    push_query(6'd5);
    // extra payload is dropped
    send_frame(3, 0);
    push_rx(8'h7F);
    push_rx(8'h00);
    push_rx(8'hEE);
    push_query(6'd5);
    wait_drained();

    // random phases across settings and idling patterns
    set_phase({64{1'b1}}, 8'h00, 8'h00, 8'hFF, 0, 0);
    random_burst(92);
    wait_drained();

    // wrap from the top register to the bottom one
    set_phase({1'b1, 62'd0, 1'b1}, 8'hFF, 8'hFF, 8'h00, 48, 0);
    random_burst(92);
    wait_drained();

    set_phase({$urandom, $urandom}, 8'($urandom), 8'($urandom), 8'($urandom), 0, 48);
    random_burst(92);
    wait_drained();

    set_phase({$urandom, $urandom} & {$urandom, $urandom}, 8'($urandom), 8'($urandom),
              8'($urandom), 38, 38);
    random_burst(92);
    wait_drained();

    // receiver held off while polls keep coming
    set_phase({$urandom, $urandom}, usp_pkg::START_MARKER_RST, usp_pkg::READ_COMMAND_RST,
              usp_pkg::RESPONSE_MARKER_RST, 0, 0);
    hold_req = hold_req + 1;
    for (int k = 0; k < 30; k++) begin
      push_poll();
      if (k % 5 == 0) push_query(pick_reg());
    end
    wait_drained();

    // nothing enabled again: ticks stay silent
    set_phase(64'd0, 8'($urandom), 8'($urandom), 8'($urandom), 38, 38);
    random_burst(20);
    wait_drained();

    if (errors == 0 && exp_words.size() == 0) begin
      $display("uart_sensor_poll_engine regression: pass");
    end else begin
      $display("uart_sensor_poll_engine regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/usp_pkg.sv
design/usp_in_if.sv
design/usp_out_if.sv
design/usp_cfg_if.sv
design/usp_ctrl.sv
design/usp_dpath.sv
design/uart_sensor_poll_engine.sv
design/usp_checker.sv
tb/tb.sv
